// ===== sv/idtp_pkg.sv =====
package idtp_pkg;

  // character codes
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [8:0] OCTET_MAX   = 9'd255;
  localparam logic [8:0] ACC_SAT     = 9'd511;
  localparam logic [2:0] FIELD_COUNT = 3'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONDIGIT = 2'd1,
    ST_RANGE    = 2'd2,
    ST_SHORT    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } idtp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
  } idtp_out_t;

endpackage

// ===== sv/idtp_parse.sv =====
module idtp_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  idtp_pkg::idtp_in_t in_word,
  output logic               res_push,
  output idtp_pkg::idtp_out_t res_word
);
  import idtp_pkg::*;

  logic [8:0]  octet_acc, octet_acc_next;
  logic [2:0]  fields_done, fields_done_next;
  logic [7:0]  octet_store [4];
  logic [7:0]  octet_store_next [4];
  status_t     first_error, first_error_next;

  logic        busy;
  logic        is_digit;
  logic        over;
  logic [12:0] acc_mul;
  logic [12:0] acc_sum;
  logic [8:0]  acc_digit;
  status_t     end_error;
  logic [2:0]  end_fields;
  logic [7:0]  end_store [4];

  assign busy     = (first_error == ST_OK) && (fields_done < FIELD_COUNT);
  assign is_digit = in_word.ch inside {[CH_ZERO:CH_NINE]};
  assign over     = octet_acc > OCTET_MAX;

  // acc * 10 + digit, saturating at 511
  assign acc_mul   = {1'b0, octet_acc, 3'b000} + {3'b000, octet_acc, 1'b0};
  assign acc_sum   = acc_mul + {5'd0, in_word.ch - CH_ZERO};
  assign acc_digit = (acc_sum > {4'd0, ACC_SAT}) ? ACC_SAT : acc_sum[8:0];

  // end item: close the open field, then check the count
  always_comb begin
    end_error  = first_error;
    end_fields = fields_done;
    for (int i = 0; i < 4; i++) begin
      end_store[i] = octet_store[i];
    end
    if (busy) begin
      if (over) begin
        end_error = ST_RANGE;
      end else begin
        end_store[fields_done[1:0]] = octet_acc[7:0];
        end_fields = fields_done + 3'd1;
      end
    end
    if (end_error == ST_OK && end_fields < FIELD_COUNT) begin
      end_error = ST_SHORT;
    end
  end

  assign res_push       = in_fire && in_word.is_end;
  assign res_word.status = end_error;
  assign res_word.address = (end_error == ST_OK) ?
      {end_store[0], end_store[1], end_store[2], end_store[3]} : 32'd0;

  always_comb begin
    octet_acc_next   = octet_acc;
    fields_done_next = fields_done;
    first_error_next = first_error;
    for (int i = 0; i < 4; i++) begin
      octet_store_next[i] = octet_store[i];
    end
    if (in_fire) begin
      if (in_word.is_end) begin
        octet_acc_next   = 9'd0;
        fields_done_next = 3'd0;
        first_error_next = ST_OK;
        for (int i = 0; i < 4; i++) begin
          octet_store_next[i] = 8'd0;
        end
      end else if (busy) begin
        if (in_word.ch == CH_DOT) begin
          if (over) begin
            first_error_next = ST_RANGE;
          end else begin
            octet_store_next[fields_done[1:0]] = octet_acc[7:0];
            fields_done_next = fields_done + 3'd1;
            octet_acc_next   = 9'd0;
          end
        end else if (is_digit) begin
          octet_acc_next = acc_digit;
        end else begin
          first_error_next = ST_NONDIGIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octet_acc   <= 9'd0;
      fields_done <= 3'd0;
      first_error <= ST_OK;
      for (int i = 0; i < 4; i++) begin
        octet_store[i] <= 8'd0;
      end
    end else begin
      octet_acc   <= octet_acc_next;
      fields_done <= fields_done_next;
      first_error <= first_error_next;
      for (int i = 0; i < 4; i++) begin
        octet_store[i] <= octet_store_next[i];
      end
    end
  end

endmodule

// ===== sv/idtp_out_buf.sv =====
module idtp_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  idtp_pkg::idtp_out_t push_word,
  output logic                push_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output idtp_pkg::idtp_out_t out_word
);
  import idtp_pkg::*;

  logic      main_valid;
  idtp_out_t main_word;
  logic      skid_valid;
  idtp_out_t skid_word;

  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_word   = main_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_word <= skid_valid ? skid_word : push_word;
    end else if (push) begin
      skid_word <= push_word;
    end
  end

endmodule

// ===== sv/ipv4_dotted_text_parser.sv =====
// Channel  Signals                              Word
// -------  -----------------------------------  ------------------------------
// char     char_valid, char_ready, char_data    ch[7:0], is_end
// addr     addr_valid, addr_ready, addr_data    status[1:0], address[31:0]
//
// One char word per cycle while char_ready is high. Each character updates
// the field accumulator in the cycle it is taken; an end word's result is
// registered before it reaches addr. Synchronous active-high rst clears the
// parser and the result buffer. A two-deep result buffer lets char keep
// flowing while a result waits; char_ready drops only when two are pending.
module ipv4_dotted_text_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  idtp_pkg::idtp_in_t  char_data,
  output logic                addr_valid,
  input  logic                addr_ready,
  output idtp_pkg::idtp_out_t addr_data
);
  import idtp_pkg::*;

  logic      char_fire;
  logic      res_push;
  idtp_out_t res_word;

  // a char word is taken whenever the result buffer has a free slot
  assign char_fire = char_valid && char_ready;

  // field accumulator, octet store and sticky error
  idtp_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (char_fire),
    .in_word  (char_data),
    .res_push (res_push),
    .res_word (res_word)
  );

  // result register with skid slot
  idtp_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_word  (res_word),
    .push_ready (char_ready),
    .out_valid  (addr_valid),
    .out_ready  (addr_ready),
    .out_word   (addr_data)
  );

endmodule
